// File: rtl/core/ffbp_pkg.sv
`default_nettype none

package ffbp_pkg;

   // Table geometry
   localparam int MAX_BINS    = 64;
   localparam int WEIGHT_BITS = 16;

   // Port field widths
   localparam int WEIGHT_W    = 16;
   localparam int CAP_W       = 16;
   localparam int IDX_FIELD_W = 6;
   localparam int CNT_FIELD_W = 7;
   localparam int STATUS_W    = 2;

   // Internal widths
   localparam int WT_W      = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
   localparam int BIN_IDX_W = $clog2(MAX_BINS);
   localparam int CNT_W     = $clog2(MAX_BINS + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_EXISTING = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic                load;
      logic                scan_clr;
      logic                scan_inc;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                commit;
   } ffbp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic too_big;
      logic open_zero;
      logic fit;
      logic last;
      logic full;
      logic slot_free;
   } ffbp_sts_type;

   // Fit a bin index into the result field (zero-extend or mask)
   function automatic logic [IDX_FIELD_W-1:0] idx_field(input logic [BIN_IDX_W-1:0] v);
      logic [BIN_IDX_W+IDX_FIELD_W-1:0] t;
      t = '0;
      t[BIN_IDX_W-1:0] = v;
      return t[IDX_FIELD_W-1:0];
   endfunction

   // Fit a bin count into the result field (zero-extend or mask)
   function automatic logic [CNT_FIELD_W-1:0] cnt_field(input logic [CNT_W-1:0] v);
      logic [CNT_W+CNT_FIELD_W-1:0] t;
      t = '0;
      t[CNT_W-1:0] = v;
      return t[CNT_FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ffbp_ctrl.sv
`default_nettype none

module ffbp_ctrl
   import ffbp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire ffbp_sts_type sts,
   output ffbp_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_READ    = 3'd2;
   localparam logic [2:0] S_COMPARE = 3'd3;
   localparam logic [2:0] S_EMIT    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Sequence one item: check, scan bins, emit
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.too_big) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_TOO_BIG;
               state_in       = S_EMIT;
            end else if (sts.open_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NEW;
               state_in       = S_EMIT;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            if (sts.fit) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_EXISTING;
               state_in       = S_EMIT;
            end else if (sts.last) begin
               cmd.set_status = 1'b1;
               cmd.status     = sts.full ? ST_FULL : ST_NEW;
               state_in       = S_EMIT;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_READ;
            end
         end
         S_EMIT: begin
            if (sts.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ffbp_dpath.sv
`default_nettype none

module ffbp_dpath
   import ffbp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [WEIGHT_W-1:0]    req_weight,
   input  wire logic                   req_first_item,
   input  wire logic [CAP_W-1:0]       bin_capacity,
   input  wire ffbp_cmd_type           cmd,
   output ffbp_sts_type                sts,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [IDX_FIELD_W-1:0]      rsp_bin_index,
   output logic [CNT_FIELD_W-1:0]      rsp_bins_used,
   output logic [STATUS_W-1:0]         rsp_status
);

   logic [WT_W-1:0] mem [MAX_BINS];

   logic [WT_W-1:0]        weight_ff, weight_in;
   logic [WT_W-1:0]        rd_ff;
   logic [CNT_W-1:0]       open_bins_ff, open_bins_in;
   logic [BIN_IDX_W-1:0]   scan_ff, scan_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_FIELD_W-1:0] rsp_bin_index_ff, rsp_bin_index_in;
   logic [CNT_FIELD_W-1:0] rsp_bins_used_ff, rsp_bins_used_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic [WT_W-1:0]      cap_w;
   logic [BIN_IDX_W-1:0] new_addr;
   logic                 mem_we;
   logic [BIN_IDX_W-1:0] mem_waddr;
   logic [WT_W-1:0]      mem_wdata;

   assign cap_w    = bin_capacity[WT_W-1:0];
   assign new_addr = open_bins_ff[BIN_IDX_W-1:0];

   // Report conditions to the controller
   always_comb begin
      sts.too_big   = (weight_ff > cap_w);
      sts.open_zero = (open_bins_ff == '0);
      sts.fit       = (rd_ff >= weight_ff);
      sts.last      = ((CNT_W'(scan_ff) + CNT_W'(1)) == open_bins_ff);
      sts.full      = (open_bins_ff == CNT_W'(MAX_BINS));
      sts.slot_free = !rsp_valid_ff || !rsp_stall;
   end

   // Pick the table update for a committed item
   always_comb begin
      mem_we    = cmd.commit && ((status_ff == ST_EXISTING) || (status_ff == ST_NEW));
      mem_waddr = (status_ff == ST_EXISTING) ? scan_ff : new_addr;
      mem_wdata = (status_ff == ST_EXISTING) ? (rd_ff - weight_ff) : (cap_w - weight_ff);
   end

   // Advance item, scan and count registers
   always_comb begin
      weight_in    = weight_ff;
      open_bins_in = open_bins_ff;
      scan_in      = scan_ff;
      status_in    = status_ff;
      if (cmd.load) begin
         weight_in = req_weight[WT_W-1:0];
         if (req_first_item) begin
            open_bins_in = '0;
         end
      end
      if (cmd.scan_clr) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + BIN_IDX_W'(1);
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.commit && (status_ff == ST_NEW)) begin
         open_bins_in = open_bins_ff + CNT_W'(1);
      end
   end

   // Load the result register on commit, drop it once taken
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_bin_index_in = rsp_bin_index_ff;
      rsp_bins_used_in = rsp_bins_used_ff;
      rsp_status_in    = rsp_status_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         case (status_ff)
            ST_EXISTING: begin
               rsp_bin_index_in = idx_field(scan_ff);
               rsp_bins_used_in = cnt_field(open_bins_ff);
            end
            ST_NEW: begin
               rsp_bin_index_in = idx_field(new_addr);
               rsp_bins_used_in = cnt_field(open_bins_ff + CNT_W'(1));
            end
            default: begin
               rsp_bin_index_in = '0;
               rsp_bins_used_in = cnt_field(open_bins_ff);
            end
         endcase
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Bin table: one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_bins_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_bins_ff <= open_bins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      weight_ff        <= weight_in;
      scan_ff          <= scan_in;
      status_ff        <= status_in;
      rsp_bin_index_ff <= rsp_bin_index_in;
      rsp_bins_used_ff <= rsp_bins_used_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_index_ff;
   assign rsp_bins_used = rsp_bins_used_ff;
   assign rsp_status    = rsp_status_ff;

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_bins_ff <= CNT_W'(MAX_BINS))
      else $error("open bin count beyond table size");

   a_new_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (status_ff == ST_NEW) |=>
         open_bins_ff == $past(open_bins_ff) + CNT_W'(1))
      else $error("new bin did not advance the count");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("commit over an untaken result");

   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_status_ff == ST_TOO_BIG) || (rsp_status_ff == ST_FULL))
         |-> (rsp_bin_index_ff == '0))
      else $error("unplaced item carries a bin index");

endmodule

`default_nettype wire

// File: rtl/core/first_fit_bin_packer_top.sv
// First-fit bin packer.
// Input channel (req_): one beat carries an item weight and a first-item flag;
// a beat is taken at a clock edge with req_valid high and req_stall low.
// A set first-item flag empties the bin table before the item is placed.
// Result channel (rsp_): one beat per item with the chosen bin, the bins in use
// and a status (existing bin, new bin, weight too large, table full).
// Config channel (csr_): csr_bin_capacity is written when csr_valid and
// csr_ready are high; write it only while no item is in flight.
// From an accepted beat the controller checks the weight, then reads and
// compares the open bins one by one (no bin is compared when the weight is
// too large or no bin is open), and loads the result into the output register.
// The bin table has one read port; each entry is read and then compared, which
// sets the scan time. One item is worked at a time: the next beat can be taken
// the cycle after the result is loaded into the output register.
// A stalled result holds in the output register; a finished item waits in
// the datapath until the register frees, and req_stall stays high meanwhile.
// Reset empties the table, drops any result and sets the capacity to 100.
`default_nettype none

module first_fit_bin_packer_top
   import ffbp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [WEIGHT_W-1:0]    req_weight,
   input  wire logic                   req_first_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [IDX_FIELD_W-1:0]      rsp_bin_index,
   output logic [CNT_FIELD_W-1:0]      rsp_bins_used,
   output logic [STATUS_W-1:0]         rsp_status,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CAP_W-1:0]       csr_bin_capacity
);

   ffbp_cmd_type cmd;
   ffbp_sts_type sts;

   logic [CAP_W-1:0] cap_ff;

   // Capacity register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_bin_capacity;
      end
   end

   ffbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffbp_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_weight     (req_weight),
      .req_first_item (req_first_item),
      .bin_capacity   (cap_ff),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_bins_used  (rsp_bins_used),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// File: tb/first_fit_bin_packer_checker.sv
`timescale 1ns / 100ps

module first_fit_bin_packer_checker
   import ffbp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [WEIGHT_W-1:0]    req_weight,
   input  wire logic                   req_first_item,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [IDX_FIELD_W-1:0] rsp_bin_index,
   input  wire logic [CNT_FIELD_W-1:0] rsp_bins_used,
   input  wire logic [STATUS_W-1:0]    rsp_status,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CAP_W-1:0]       csr_bin_capacity,
   output int                          error_count,
   output int                          placements_owed
);

   localparam int DUE_DEPTH = 64;
   localparam int DUE_PTR_W = 6;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] bin_index;
      logic [CNT_FIELD_W-1:0] bins_used;
      logic [STATUS_W-1:0]    status;
   } placement_type;

   // Shadow copy of the bin table and the capacity register
   logic [WEIGHT_W-1:0]  bin_left [MAX_BINS];
   int unsigned          bins_open = 0;
   logic [CAP_W-1:0]     capacity  = CAP_RESET;
   placement_type        placements_due [DUE_DEPTH];
   logic [DUE_PTR_W-1:0] due_wr    = '0;
   logic [DUE_PTR_W-1:0] due_rd    = '0;
   int                   due_count = 0;
   int                   errors    = 0;

   assign error_count = errors;

   // Place one item first-fit and return the placement it should produce
   function automatic placement_type place_item(input logic [WEIGHT_W-1:0] weight,
                                                input logic first);
      placement_type p;
      if (first) begin
         bins_open = 0;
      end
      p.bin_index = '0;
      p.bins_used = CNT_FIELD_W'(bins_open);
      // oversized weight is flagged before any search
      if (weight > capacity) begin
         p.status = ST_TOO_BIG;
         return p;
      end
      for (int slot = 0; slot < bins_open; slot++) begin
         if (bin_left[slot] >= weight) begin
            bin_left[slot] = bin_left[slot] - weight;
            p.bin_index    = IDX_FIELD_W'(slot);
            p.status       = ST_EXISTING;
            return p;
         end
      end
      // no room anywhere and no free slot left
      if (bins_open >= MAX_BINS) begin
         p.status = ST_FULL;
         return p;
      end
      bin_left[bins_open] = capacity - weight;
      p.bin_index         = IDX_FIELD_W'(bins_open);
      bins_open           = bins_open + 1;
      p.bins_used         = CNT_FIELD_W'(bins_open);
      p.status            = ST_NEW;
      return p;
   endfunction

   // Track config writes, predict on each request beat, compare each response beat
   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         bins_open = 0;
         capacity  = CAP_RESET;
         due_wr    = '0;
         due_rd    = '0;
         due_count = 0;
         placements_owed <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity = csr_bin_capacity;
         end
         if (req_valid && !req_stall) begin
            placements_due[due_wr] = place_item(req_weight, req_first_item);
            due_wr    = due_wr + DUE_PTR_W'(1);
            due_count = due_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_count == 0) begin
               if (errors < 10) begin
                  $display("%0t: unexpected response beat bin %0d used %0d status %0d",
                           $realtime, rsp_bin_index, rsp_bins_used, rsp_status);
               end
               errors++;
            end else begin
               want      = placements_due[due_rd];
               due_rd    = due_rd + DUE_PTR_W'(1);
               due_count = due_count - 1;
               if (rsp_bin_index !== want.bin_index || rsp_bins_used !== want.bins_used ||
                   rsp_status !== want.status) begin
                  if (errors < 10) begin
                     $display("%0t: wrong beat: bin %0d (exp %0d) used %0d (exp %0d)",
                              $realtime, rsp_bin_index, want.bin_index, rsp_bins_used,
                              want.bins_used, " status %0d (exp %0d)", rsp_status,
                              want.status);
                  end
                  errors++;
               end
            end
         end
         placements_owed <= due_count;
      end
   end

endmodule

// File: tb/first_fit_bin_packer_top_test.sv
`timescale 1ns / 100ps

module first_fit_bin_packer_top_test
   import ffbp_pkg::*;
();

   localparam int RUN_LIMIT    = 1000000;
   localparam int RANDOM_ITEMS = 900;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [WEIGHT_W-1:0]    req_weight       = '0;
   logic                   req_first_item   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [IDX_FIELD_W-1:0] rsp_bin_index;
   logic [CNT_FIELD_W-1:0] rsp_bins_used;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CAP_W-1:0]       csr_bin_capacity = '0;

   int               error_count;
   int               placements_owed;
   int unsigned      cycle_count = 0;
   bit               calm        = 1'b0;
   int               gap_odds    = 0;
   logic [CAP_W-1:0] cur_cap     = CAP_RESET;

   first_fit_bin_packer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_weight       (req_weight),
      .req_first_item   (req_first_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bins_used    (rsp_bins_used),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bin_capacity (csr_bin_capacity)
   );

   first_fit_bin_packer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_weight       (req_weight),
      .req_first_item   (req_first_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bins_used    (rsp_bins_used),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bin_capacity (csr_bin_capacity),
      .error_count      (error_count),
      .placements_owed  (placements_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stall the response side in random bursts, with quiet stretches between
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(0, 30)) @(posedge clock);
         end
      end
   end

   // Drop valid and hold until every placement has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (placements_owed != 0);
   endtask

   // Write the capacity register while the packer is idle
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_for_results();
      csr_valid        <= 1'b1;
      csr_bin_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_cap = value;
   endtask

   // Send one item beat, with an occasional idle burst ahead of it
   task automatic send_item(input logic [WEIGHT_W-1:0] weight, input logic first);
      if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_weight     <= weight;
      req_first_item <= first;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [CAP_W-1:0] pick_capacity();
      case ($urandom_range(0, 6))
         0:       return 16'd1;
         1:       return 16'd2;
         2:       return CAP_W'($urandom_range(3, 20));
         3:       return 16'd100;
         4:       return CAP_W'($urandom_range(1, 65535));
         5:       return 16'hFFFF;
         default: return 16'd0;
      endcase
   endfunction

   // Mostly weights that fit, plus zero, exact fits and oversized ones
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return cur_cap;
         2:       return (cur_cap == 16'hFFFF) ? WEIGHT_W'($urandom_range(0, 65535)) :
                                                 WEIGHT_W'($urandom_range(cur_cap + 1, 65535));
         3:       return WEIGHT_W'($urandom_range(0, 65535));
         4:       return WEIGHT_W'($urandom_range(0, cur_cap / 4));
         default: return WEIGHT_W'($urandom_range(0, cur_cap));
      endcase
   endfunction

   initial begin
      int sent;
      int set_len;
      bit fill;
      bit carry_on;
      bit first;
      logic [WEIGHT_W-1:0] weight;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: zero weight, exact fit, oversized, new bins, new set
      send_item(16'd0, 1'b1);
      send_item(16'd100, 1'b0);
      send_item(16'd101, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd60, 1'b0);
      send_item(16'd40, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'd70, 1'b1);

      // Largest capacity
      write_capacity(16'hFFFF);
      send_item(16'hFFFF, 1'b1);
      send_item(16'd0, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h5555, 1'b0);
      send_item(16'hAAAA, 1'b0);

      // Shrink capacity mid-set: open bins keep what they have left
      write_capacity(16'd10);
      send_item(16'd11, 1'b0);
      send_item(16'd10, 1'b0);
      send_item(16'd5, 1'b0);

      // Zero capacity: only zero weights are placed
      write_capacity(16'd0);
      send_item(16'd0, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);

      write_capacity(16'd1);
      send_item(16'd1, 1'b1);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);

      // Random sets; the first one fills the table to overflow
      sent = 0;
      fill = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            write_capacity(pick_capacity());
         end
         if (fill && cur_cap == 0) begin
            write_capacity(CAP_W'($urandom_range(1, 65535)));
         end
         gap_odds = $urandom_range(0, 4);
         set_len  = fill ? $urandom_range(66, 72) : $urandom_range(1, 30);
         carry_on = !fill && $urandom_range(0, 4) == 0;
         for (int i = 0; i < set_len; i++) begin
            if (fill) begin
               weight = WEIGHT_W'($urandom_range(cur_cap / 2 + 1, cur_cap));
               first  = (i == 0);
            end else begin
               weight = pick_weight();
               first  = (i == 0 && !carry_on) || $urandom_range(0, 40) == 0;
            end
            send_item(weight, first);
            sent++;
            if (sent >= RANDOM_ITEMS - 120) begin
               calm = 1'b1;
            end
            if (!calm && $urandom_range(0, 60) == 0) begin
               wait_for_results();
            end
         end
         fill = $urandom_range(0, 7) == 0;
      end

      // Drain, then watch for stray beats
      wait_for_results();
      repeat (20) @(posedge clock);
      if (error_count == 0 && placements_owed == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
